// ===== rtl/psmrl_pkg.sv =====
// shared types, constants and helper functions for the mouse packet rate limiter
// no dependencies
package psmrl_pkg;

    localparam int unsigned PERIOD_W = 20;
    localparam int unsigned STANDOFF_W = 8;
    localparam int unsigned ELAPSED_W = 21;
    localparam int unsigned SUM_W = 16;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STANDOFF_COUNT = 1'd1;

    localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RST = 20'd25000;
    localparam logic [STANDOFF_W-1:0] STANDOFF_COUNT_RST = 8'd10;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    localparam int unsigned SYNC_BIT = 3;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    localparam logic [1:0] BYTE_IDX_HDR = 2'd0;
    localparam logic [1:0] BYTE_IDX_X = 2'd1;
    localparam logic [1:0] BYTE_IDX_Y = 2'd2;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_ARM  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        SYNC_HDR  = 4'b0001,
        SYNC_X    = 4'b0010,
        SYNC_Y    = 4'b0100,
        SYNC_NONE = 4'b1000
    } sync_t;

    typedef struct packed {
        logic       is_packet;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } job_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic [7:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W-7){b[7]}}, b};
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
        if ((&v[SUM_W-1:7]) || !(|v[SUM_W-1:7]))
            return v[7:0];
        return v[SUM_W-1] ? 8'h80 : 8'h7f;
    endfunction

endpackage

// ===== rtl/psmrl_ifs.sv =====
// valid/ready channel interfaces for the input items and the output bytes
// depends on nothing but the handshake convention
interface psmrl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] in_byte;

    modport source(output valid, output operation, output in_byte, input ready);
    modport sink(input valid, input operation, input in_byte, output ready);
endinterface

interface psmrl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source(output valid, output out_byte, output last_of_run, input ready);
    modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== rtl/psmrl_front.sv =====
// front part: config registers, sync tracking, delta sums and rate limit
// depends on psmrl_pkg and psmrl_ifs; pushes output jobs into psmrl_queue
module psmrl_front
    import psmrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    psmrl_in_if.sink              in_ch,
    input  logic                  q_full,
    output logic                  push,
    output job_t                  push_job
);

    logic [PERIOD_W-1:0]   report_period_reg;
    logic [STANDOFF_W-1:0] standoff_count_reg;
    sync_t                 sync_reg, sync_next;
    logic [7:0]            header_reg, header_next;
    logic signed [SUM_W-1:0] x_sum_reg, x_sum_next;
    logic signed [SUM_W-1:0] y_sum_reg, y_sum_next;
    logic [STANDOFF_W-1:0] standoff_left_reg, standoff_left_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                  accept;
    logic signed [SUM_W-1:0] y_sum_new;

    assign in_ch.ready = !q_full;
    assign accept = in_ch.valid && in_ch.ready;
    assign y_sum_new = sat_add(y_sum_reg, in_ch.in_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_period_reg  <= REPORT_PERIOD_RST;
            standoff_count_reg <= STANDOFF_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPORT_PERIOD:  report_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_STANDOFF_COUNT: standoff_count_reg <= cfg_data[STANDOFF_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        sync_next          = sync_reg;
        header_next        = header_reg;
        x_sum_next         = x_sum_reg;
        y_sum_next         = y_sum_reg;
        standoff_left_next = standoff_left_reg;
        elapsed_next       = elapsed_reg;
        push               = 1'b0;
        push_job           = '{is_packet: 1'b0, b0: in_ch.in_byte,
                               b1: clamp8(x_sum_reg), b2: clamp8(y_sum_new)};
        if (accept)
        begin
            unique case (op_t'(in_ch.operation))
                OP_TICK:
                begin
                    if (elapsed_reg != ELAPSED_MAX)
                        elapsed_next = elapsed_reg + 1'b1;
                end
                OP_ARM:
                    standoff_left_next = standoff_count_reg;
                OP_BYTE:
                begin
                    if (standoff_left_reg != '0)
                    begin
                        push               = 1'b1;
                        standoff_left_next = standoff_left_reg - 1'b1;
                        elapsed_next       = ELAPSED_MAX;
                    end
                    else
                    begin
                        unique case (sync_reg)
                            SYNC_NONE:
                            begin
                                if (in_ch.in_byte[SYNC_BIT])
                                begin
                                    header_next = in_ch.in_byte;
                                    sync_next   = SYNC_X;
                                end
                            end
                            SYNC_HDR:
                            begin
                                if (in_ch.in_byte[SYNC_BIT])
                                begin
                                    header_next = in_ch.in_byte;
                                    sync_next   = SYNC_X;
                                end
                                else
                                begin
                                    header_next = '0;
                                    x_sum_next  = '0;
                                    y_sum_next  = '0;
                                    sync_next   = SYNC_NONE;
                                end
                            end
                            SYNC_X:
                            begin
                                x_sum_next = sat_add(x_sum_reg, in_ch.in_byte);
                                sync_next  = SYNC_Y;
                            end
                            SYNC_Y:
                            begin
                                sync_next  = SYNC_HDR;
                                y_sum_next = y_sum_new;
                                if (elapsed_reg > {1'b0, report_period_reg})
                                begin
                                    push               = 1'b1;
                                    push_job.is_packet = 1'b1;
                                    push_job.b0        = header_reg;
                                    header_next        = '0;
                                    x_sum_next         = '0;
                                    y_sum_next         = '0;
                                    elapsed_next       = '0;
                                end
                            end
                            default:
                                sync_next = SYNC_NONE;
                        endcase
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg          <= SYNC_NONE;
            header_reg        <= '0;
            x_sum_reg         <= '0;
            y_sum_reg         <= '0;
            standoff_left_reg <= '0;
            elapsed_reg       <= ELAPSED_MAX;
        end
        else
        begin
            sync_reg          <= sync_next;
            header_reg        <= header_next;
            x_sum_reg         <= x_sum_next;
            y_sum_reg         <= y_sum_next;
            standoff_left_reg <= standoff_left_next;
            elapsed_reg       <= elapsed_next;
        end
    end

    // synced positions past the header always hold a header with the sync bit
    a_hdr_sync_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (sync_reg == SYNC_X || sync_reg == SYNC_Y) |-> header_reg[SYNC_BIT])
        else $error("header without sync bit while mid-packet");

    a_unsynced_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (sync_reg == SYNC_HDR && accept && in_ch.operation == OP_BYTE
         && standoff_left_reg == '0 && !in_ch.in_byte[SYNC_BIT])
        |=> (sync_reg == SYNC_NONE && x_sum_reg == '0 && y_sum_reg == '0))
        else $error("lost sync did not clear the sums");

    a_push_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_job.is_packet) |=> (elapsed_reg == '0))
        else $error("forwarded report did not restart the period");

endmodule

// ===== rtl/psmrl_queue.sv =====
// short job queue between the front and back parts
// depends on psmrl_pkg for the job type and depth
module psmrl_queue
    import psmrl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head_job
);

    job_t               entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with the count");

endmodule

// ===== rtl/psmrl_back.sv =====
// back part: serializes queued jobs into output bytes through an output register
// depends on psmrl_pkg and psmrl_ifs; pops jobs from psmrl_queue
module psmrl_back
    import psmrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  job_t        q_head,
    output logic        pop,
    psmrl_out_if.source out_ch
);

    logic       busy_reg, busy_next;
    job_t       job_reg, job_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       can_emit;
    logic       last_byte;
    logic [7:0] sel_byte;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.last_of_run = out_last_reg;

    assign can_emit  = !out_valid_reg || out_ch.ready;
    assign last_byte = !job_reg.is_packet || (idx_reg == BYTE_IDX_Y);

    always_comb
    begin
        unique case (idx_reg)
            BYTE_IDX_HDR: sel_byte = job_reg.b0;
            BYTE_IDX_X:   sel_byte = job_reg.b1;
            default:      sel_byte = job_reg.b2;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;
        if (busy_reg && can_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_last_next  = last_byte;
            if (last_byte)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
        if ((!busy_reg || (can_emit && last_byte)) && q_not_empty)
        begin
            pop       = 1'b1;
            busy_next = 1'b1;
            job_next  = q_head;
            idx_next  = BYTE_IDX_HDR;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= BYTE_IDX_HDR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg == BYTE_IDX_HDR || idx_reg == BYTE_IDX_X
                      || idx_reg == BYTE_IDX_Y))
        else $error("byte index out of range");

    a_single_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !job_reg.is_packet) |-> (idx_reg == BYTE_IDX_HDR))
        else $error("single-byte job past its first byte");

    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && can_emit && last_byte && !q_not_empty) |=> !busy_reg)
        else $error("job still busy after its last byte");

endmodule

// ===== rtl/ps2_mouse_packet_rate_limiter.sv =====
// path: an input's first result byte passes the queue entry, the job register and the output register
// throughput: one input per cycle while the job queue is not full; each forwarded packet leaves as three
// output bytes, and a two-entry job queue lets input continue while bytes drain
// reset: report_period 25000, standoff_count 10, unsynced, sums and standoff cleared,
// elapsed time saturated so the first complete packet is forwarded
module ps2_mouse_packet_rate_limiter
    import psmrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    psmrl_in_if.sink              in_ch,
    psmrl_out_if.source           out_ch
);

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    psmrl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    psmrl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    psmrl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (head_job),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

// ===== sim/psmrl_report_check.sv =====
// predicts the forwarded mouse bytes from the accepted input transactions and compares them
// with the output transactions; depends on psmrl_pkg and the channel interfaces in psmrl_ifs
module psmrl_report_check import psmrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    psmrl_in_if                   in_mon,
    psmrl_out_if                  out_mon,
    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FRAME_HDR  = 2'd0;
    localparam logic [1:0] FRAME_X    = 2'd1;
    localparam logic [1:0] FRAME_Y    = 2'd2;
    localparam logic [1:0] FRAME_LOST = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    out_beat_t expected_bytes[$];
    out_beat_t want;

    logic [PERIOD_W-1:0]    min_gap_us;
    logic [STANDOFF_W-1:0]  standoff_reload;
    logic [1:0]             frame_pos;
    logic [7:0]             hdr_byte;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [STANDOFF_W-1:0]  passthru_left;
    logic [ELAPSED_W-1:0]   since_report;

    function automatic logic signed [SUM_W-1:0] accumulate(
        input logic signed [SUM_W-1:0] acc,
        input logic [7:0] delta
    );
        int s;
        s = int'(acc) + int'($signed(delta));
        if (s > 32767)
            s = 32767;
        else if (s < -32768)
            s = -32768;
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [7:0] clamp_delta(input logic signed [SUM_W-1:0] acc);
        int v;
        v = int'(acc);
        if (v > 127)
            v = 127;
        else if (v < -128)
            v = -128;
        return v[7:0];
    endfunction

    task automatic expect_byte(input logic [7:0] data, input logic last);
        out_beat_t beat;
        beat.data = data;
        beat.last = last;
        expected_bytes.push_back(beat);
    endtask

    task automatic clear_frame();
        hdr_byte = 8'h00;
        sum_x = '0;
        sum_y = '0;
    endtask

    task automatic predict_item(input op_t op, input logic [7:0] b);
        case (op)
            OP_TICK:
            begin
                if (since_report != ELAPSED_MAX)
                    since_report = since_report + 1'b1;
            end
            OP_ARM:
            begin
                passthru_left = standoff_reload;
            end
            OP_BYTE:
            begin
                if (passthru_left != '0)
                begin
                    expect_byte(b, 1'b1);
                    passthru_left = passthru_left - 1'b1;
                    since_report = ELAPSED_MAX;
                end
                else if (frame_pos == FRAME_LOST)
                begin
                    if (b[SYNC_BIT])
                    begin
                        hdr_byte = b;
                        frame_pos = FRAME_X;
                    end
                end
                else
                begin
                    case (frame_pos)
                        FRAME_HDR: hdr_byte = b;
                        FRAME_X:   sum_x = accumulate(sum_x, b);
                        default:   sum_y = accumulate(sum_y, b);
                    endcase
                    if (!hdr_byte[SYNC_BIT])
                    begin
                        frame_pos = FRAME_LOST;
                        clear_frame();
                    end
                    else if (frame_pos == FRAME_Y)
                    begin
                        frame_pos = FRAME_HDR;
                        if (since_report > ELAPSED_W'(min_gap_us))
                        begin
                            expect_byte(hdr_byte, 1'b0);
                            expect_byte(clamp_delta(sum_x), 1'b0);
                            expect_byte(clamp_delta(sum_y), 1'b1);
                            clear_frame();
                            since_report = '0;
                        end
                    end
                    else
                    begin
                        frame_pos = frame_pos + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_us = REPORT_PERIOD_RST;
            standoff_reload = STANDOFF_COUNT_RST;
            frame_pos = FRAME_LOST;
            clear_frame();
            passthru_left = '0;
            since_report = ELAPSED_MAX;
            expected_bytes.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_REPORT_PERIOD)
                    min_gap_us = cfg_data[PERIOD_W-1:0];
                else if (cfg_index == CFG_STANDOFF_COUNT)
                    standoff_reload = cfg_data[STANDOFF_W-1:0];
            end
            if (in_mon.valid && in_mon.ready)
                predict_item(op_t'(in_mon.operation), in_mon.in_byte);
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte expected none actual %02h", out_mon.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_mon.out_byte !== want.data)
                    begin
                        $error("out_byte expected %02h actual %02h", want.data, out_mon.out_byte);
                        mismatches++;
                    end
                    if (out_mon.last_of_run !== want.last)
                    begin
                        $error("last_of_run expected %0b actual %0b", want.last,
                               out_mon.last_of_run);
                        mismatches++;
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// ===== sim/tb_ps2_mouse_packet_rate_limiter.sv =====
// top of the mouse packet rate limiter testbench: clock, reset, register writes and
// randomized input and output handshakes; depends on psmrl_pkg, psmrl_ifs and psmrl_report_check
module tb_ps2_mouse_packet_rate_limiter import psmrl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int HELD_PACKETS  = 4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    mismatches;
    int                    pending;
    bit                    calm = 1'b0;
    bit                    hold_results = 1'b0;

    psmrl_in_if  in_ch();
    psmrl_out_if out_ch();

    ps2_mouse_packet_rate_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    psmrl_report_check report_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 5))
            0: return 8'h7f;
            1: return 8'h80;
            2: return 8'h00;
            3: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input op_t op, input logic [7:0] b);
        int  gap;
        logic took;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.in_byte <= b;
        do
        begin
            @(negedge clk);
            took = in_ch.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_item(OP_BYTE, hdr);
        send_item(OP_BYTE, dx);
        send_item(OP_BYTE, dy);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [PERIOD_W-1:0] period,
                                input logic [STANDOFF_W-1:0] reload);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= CFG_REPORT_PERIOD;
        cfg_data <= CFG_DATA_W'(period);
        @(posedge clk);
        cfg_index <= CFG_STANDOFF_COUNT;
        cfg_data <= CFG_DATA_W'(reload);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_traffic(input int n_items, input bit with_hold);
        int  sent;
        int  pick;
        int  burst;
        bit  held;
        sent = 0;
        held = 1'b0;
        while (sent < n_items)
        begin
            if (with_hold && !held && sent >= n_items / 2)
            begin
                // output stalled for a long stretch while packets keep coming
                held = 1'b1;
                calm = 1'b1;
                hold_results = 1'b1;
                repeat (5)
                begin
                    repeat (3) send_item(OP_TICK, 8'($urandom));
                    send_packet(8'($urandom) | 8'h08, pick_delta(), pick_delta());
                end
                calm = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                burst = $urandom_range(0, 3);
                repeat (burst) send_item(OP_TICK, 8'($urandom));
                send_packet(8'($urandom) | 8'h08, pick_delta(), pick_delta());
                sent += 3;
            end
            else if (pick < 72)
            begin
                burst = $urandom_range(1, 70);
                repeat (burst) send_item(OP_TICK, 8'($urandom));
                sent += burst;
            end
            else if (pick < 77)
            begin
                send_item(OP_ARM, 8'($urandom));
                sent++;
            end
            else if (pick < 87)
            begin
                send_item(OP_BYTE, 8'($urandom));
                sent++;
            end
            else if (pick < 92)
            begin
                send_item(OP_NONE, 8'($urandom));
            end
            else
            begin
                // header and one delta byte followed by a byte that cannot be a header
                send_item(OP_BYTE, 8'($urandom) | 8'h08);
                send_item(OP_BYTE, pick_delta());
                send_item(OP_BYTE, 8'($urandom) & 8'hf7);
                sent += 3;
            end
        end
    endtask

    initial
    begin : result_sink
        int   stall;
        logic seen;
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                seen = out_ch.valid;
                @(posedge clk);
            end
            while (!seen);
        end
    end

    initial
    begin : stimulus
        in_ch.valid = 1'b0;
        in_ch.operation = OP_BYTE;
        in_ch.in_byte = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first packet goes out, the next is held back
        send_item(OP_NONE, 8'hff);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_packet(8'h08, 8'h00, 8'hff);
        send_packet(8'hff, 8'h7f, 8'h80);
        send_item(OP_BYTE, 8'hf7);
        send_item(OP_BYTE, 8'h80);

        program_regs(20'd0, 8'd1);
        send_item(OP_ARM, 8'h00);
        send_item(OP_BYTE, 8'haa);
        send_item(OP_TICK, 8'hff);
        send_packet(8'h18, 8'h80, 8'h7f);
        send_packet(8'h28, 8'h01, 8'h01);
        send_item(OP_TICK, 8'h00);
        send_packet(8'h38, 8'hff, 8'h02);

        program_regs(20'd0, 8'd0);
        random_traffic(20, 1'b0);

        // hold reports back while the sums grow past the delta range
        program_regs(20'hfffff, 8'd10);
        repeat (3) send_item(OP_BYTE, 8'h00);
        repeat (HELD_PACKETS) send_packet(8'($urandom) | 8'h08, 8'h7f, 8'h80);

        program_regs(20'd0, 8'd1);
        send_item(OP_TICK, 8'h00);
        send_packet(8'h08, 8'h00, 8'h00);
        random_traffic(15, 1'b0);

        program_regs(20'd2, 8'd3);
        random_traffic(30, 1'b1);

        program_regs(20'd60, 8'd255);
        calm = 1'b1;
        random_traffic(20, 1'b0);
        calm = 1'b0;

        drain_results();
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/psmrl_pkg.sv
rtl/psmrl_ifs.sv
rtl/psmrl_front.sv
rtl/psmrl_queue.sv
rtl/psmrl_back.sv
rtl/ps2_mouse_packet_rate_limiter.sv
sim/psmrl_report_check.sv
sim/tb_ps2_mouse_packet_rate_limiter.sv
